// ===== rtl/mu7enc_pkg.sv =====
`default_nettype none

package mu7enc_pkg;

	// Most characters that one code unit can cause.
	localparam int unsigned MaxChars = 5;
	localparam int unsigned CountW   = $clog2(MaxChars + 1);

	localparam logic [15:0] PrintLo  = 16'h0020;
	localparam logic [15:0] PrintHi  = 16'h007E;
	localparam logic [15:0] UnitAmp  = 16'h0026;
	localparam logic [6:0]  CharAmp  = 7'h26;
	localparam logic [6:0]  CharDash = 7'h2D;

	typedef struct packed {
		logic       in_run;
		logic [3:0] pend_bits;
		logic [2:0] pend_count;
	} state_t;

	typedef struct packed {
		logic [MaxChars-1:0][6:0] chars;
		logic [CountW-1:0]        count;
	} group_t;

	// One digit of the alphabet A-Z a-z 0-9 + , as an ASCII code.
	function automatic logic [6:0] digit_char(input logic [5:0] v);
		logic [6:0] c;
		c = 7'h2C;
		if (v < 6'd26) begin
			c = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'h61 + {1'b0, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 7'h30 + {1'b0, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 7'h2B;
		end
		return c;
	endfunction

	// Leftover bits of a run, left-aligned and zero-padded to one digit.
	function automatic logic [5:0] pad_digit(input logic [3:0] bits, input logic [2:0] cnt);
		logic [5:0] w;
		w = {2'b00, bits};
		return w << (3'd6 - cnt);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mu7_unit_if.sv =====
`default_nettype none

interface mu7_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

`default_nettype wire

// ===== rtl/mu7_char_if.sv =====
`default_nettype none

interface mu7_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_of_item;
	logic       last_of_string;

	modport source (output valid, output out_char, output last_of_item,
		output last_of_string, input ready);
	modport sink (input valid, input out_char, input last_of_item,
		input last_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/modified_utf7_encoder_core.sv =====
`default_nettype none

// Channel  Direction  Carries
// units    in         code_unit[15:0], last_unit
// chars    out        out_char[6:0], last_of_item, last_of_string
//
// An item on units is a UTF-16 code unit; it yields one to five items on
// chars, one per cycle while chars is ready, sent by the character emitter.
// A unit is held in an input register; combinational logic expands it into
// its whole group of characters, which loads into the emitter register.
// The next unit is taken while the emitter still drains, and moves in on the
// cycle that the last character of the previous group is taken.
// Reset clears the run state and all valid flags; no clearing pass is needed.
// A stall on chars holds the current character and, once the input register
// is full, stalls units.
module modified_utf7_encoder_core (
	input wire logic  clk,
	input wire logic  arst_n,
	mu7_unit_if.sink  units,
	mu7_char_if.source chars
);

	// Input register.
	logic        in_valid_s1;
	logic [15:0] in_code_s1;
	logic        in_last_s1;

	// Run state that the next unit sees.
	mu7enc_pkg::state_t state_q;

	// Emitter: the group of characters of the unit now being sent.
	logic                                   emit_valid_q;
	logic [mu7enc_pkg::MaxChars-1:0][6:0]   emit_chars_s2;
	logic [mu7enc_pkg::CountW-1:0]          emit_count_s2;
	logic                                   emit_last_s2;
	logic [mu7enc_pkg::CountW-1:0]          idx_q;

	mu7enc_pkg::group_t grp;
	mu7enc_pkg::state_t nxt;

	logic at_final;
	logic emit_done;
	logic emit_free;
	logic s1_move;
	logic in_take;

	mu7_expand u_expand (
		.code_unit (in_code_s1),
		.last_unit (in_last_s1),
		.cur       (state_q),
		.grp       (grp),
		.nxt       (nxt)
	);

	// The emitter is free when empty or when its final character leaves now.
	assign at_final  = (idx_q == emit_count_s2 - 1'b1);
	assign emit_done = emit_valid_q && chars.ready && at_final;
	assign emit_free = !emit_valid_q || emit_done;
	assign s1_move   = in_valid_s1 && emit_free;

	assign units.ready = !in_valid_s1 || s1_move;
	assign in_take     = units.valid && units.ready;

	assign chars.valid          = emit_valid_q;
	assign chars.out_char       = emit_chars_s2[idx_q];
	assign chars.last_of_item   = at_final;
	assign chars.last_of_string = at_final && emit_last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			state_q      <= '0;
			emit_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (in_take) begin
				in_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				in_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				state_q      <= nxt;
				emit_valid_q <= 1'b1;
				idx_q        <= '0;
			end else if (emit_done) begin
				emit_valid_q <= 1'b0;
			end else if (emit_valid_q && chars.ready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_code_s1 <= units.code_unit;
			in_last_s1 <= units.last_unit;
		end
		if (s1_move) begin
			emit_chars_s2 <= grp.chars;
			emit_count_s2 <= grp.count;
			emit_last_s2  <= in_last_s1;
		end
	end

	// The character index never runs past the loaded group.
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid_q |-> (idx_q < emit_count_s2) && (emit_count_s2 != '0))
		else $error("emitter index outside its group");

	// Only whole code units leave 0, 2 or 4 bits behind.
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend_count == 3'd0 || state_q.pend_count == 3'd2 ||
		state_q.pend_count == 3'd4)
		else $error("pending bit count is odd or too large");

	// Outside a run no bits may be pending.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.in_run |-> (state_q.pend_count == 3'd0) && (state_q.pend_bits == 4'd0))
		else $error("pending bits outside a run");

	// The end of a string returns the run state to its reset values.
	a_string_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && in_last_s1 |=> !state_q.in_run && (state_q.pend_count == 3'd0))
		else $error("run state not cleared after last unit");

	// A group that leaves must be followed by a new load or an empty emitter.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done && !s1_move |=> !emit_valid_q)
		else $error("emitter still valid after its final character");

endmodule

`default_nettype wire

// ===== rtl/mu7_expand.sv =====
`default_nettype none

// Turns one code unit and the run state into its group of characters
// and the run state that follows it.
module mu7_expand (
	input  wire logic [15:0]         code_unit,
	input  wire logic                last_unit,
	input  wire mu7enc_pkg::state_t  cur,
	output mu7enc_pkg::group_t       grp,
	output mu7enc_pkg::state_t       nxt
);

	logic printable;

	assign printable = (code_unit >= mu7enc_pkg::PrintLo) && (code_unit <= mu7enc_pkg::PrintHi);

	always_comb begin
		logic [mu7enc_pkg::CountW-1:0] n;
		logic [2:0]  cnt;
		logic [3:0]  pb;
		logic [19:0] acc;
		logic [4:0]  total;
		logic [4:0]  sh;
		grp = '0;
		nxt = cur;
		n = '0;
		cnt = '0;
		pb = '0;
		acc = '0;
		total = '0;
		sh = '0;
		if (printable) begin
			if (cur.in_run) begin
				if (cur.pend_count != 3'd0 && cur.pend_count < 3'd6) begin
					grp.chars[n] = mu7enc_pkg::digit_char(
						mu7enc_pkg::pad_digit(cur.pend_bits, cur.pend_count));
					n = n + 1'b1;
				end
				grp.chars[n] = mu7enc_pkg::CharDash;
				n = n + 1'b1;
			end
			grp.chars[n] = code_unit[6:0];
			n = n + 1'b1;
			if (code_unit == mu7enc_pkg::UnitAmp) begin
				grp.chars[n] = mu7enc_pkg::CharDash;
				n = n + 1'b1;
			end
			nxt = '0;
		end else begin
			if (!cur.in_run) begin
				grp.chars[n] = mu7enc_pkg::CharAmp;
				n = n + 1'b1;
			end else begin
				cnt = (cur.pend_count > 3'd4) ? 3'd4 : cur.pend_count;
				pb  = cur.pend_bits;
			end
			acc   = {pb, code_unit};
			total = {2'b00, cnt} + 5'd16;
			// At most three full digits leave per unit; a last unit may add one padded digit.
			for (int k = 0; k < 3; k++) begin
				if (total >= 5'd6) begin
					sh = total - 5'd6;
					grp.chars[n] = mu7enc_pkg::digit_char(6'(acc >> sh));
					n = n + 1'b1;
					total = sh;
				end
			end
			nxt.in_run     = 1'b1;
			nxt.pend_count = total[2:0];
			nxt.pend_bits  = 4'(acc & ((20'd1 << total) - 20'd1));
			if (last_unit) begin
				if (total != 5'd0) begin
					grp.chars[n] = mu7enc_pkg::digit_char(
						mu7enc_pkg::pad_digit(nxt.pend_bits, total[2:0]));
					n = n + 1'b1;
				end
				grp.chars[n] = mu7enc_pkg::CharDash;
				n = n + 1'b1;
			end
		end
		if (last_unit) begin
			nxt = '0;
		end
		grp.count = n;
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_modified_utf7_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_modified_utf7_encoder_core;

	// One character as the encoder should emit it.
	typedef struct packed {
		logic [6:0] ch;
		logic       end_item;
		logic       end_string;
	} char_item_t;

	// One UTF-16 code unit waiting to be offered to the encoder.
	typedef struct packed {
		logic [15:0] code;
		logic        last;
	} unit_item_t;

	logic clk;
	logic arst_n;

	// The testbench owns these registers, and the interface signals follow them.
	// Their initial values keep every input of the block known from time zero.
	logic        unit_valid = 1'b0;
	logic [15:0] unit_code  = 16'h0000;
	logic        unit_last  = 1'b0;
	logic        char_ready = 1'b0;

	mu7_unit_if units_bus ();
	mu7_char_if chars_bus ();

	assign units_bus.valid     = unit_valid;
	assign units_bus.code_unit = unit_code;
	assign units_bus.last_unit = unit_last;
	assign chars_bus.ready     = char_ready;

	modified_utf7_encoder_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.units  (units_bus),
		.chars  (chars_bus)
	);

	unit_item_t pending_units[$];
	char_item_t expected_chars[$];
	char_item_t char_group[$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	logic pressure_go      = 1'b0;
	logic rx_hold          = 1'b0;
	int mismatches         = 0;

	// The encoder state as the predictor tracks it.
	logic       run_open;
	logic [3:0] left_bits;
	logic [2:0] left_count;

	string digit_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void emit_char(input logic [6:0] c);
		char_item_t item;
		item.ch         = c;
		item.end_item   = 1'b0;
		item.end_string = 1'b0;
		char_group = {char_group, item};
	endfunction

	function automatic void emit_digit(input logic [5:0] v);
		byte b;
		b = digit_set[v];
		emit_char(b[6:0]);
	endfunction

	// Closes an open base64 run: the leftover bits go out left-aligned and
	// zero-padded as one digit, then the dash. No digit when nothing is left.
	function automatic void close_open_run();
		logic [5:0] pad;
		if (run_open) begin
			if (left_count > 0 && left_count < 6) begin
				pad = {2'b00, left_bits};
				pad = pad << (6 - left_count);
				emit_digit(pad);
			end
			emit_char(mu7enc_pkg::CharDash);
		end
		run_open   = 1'b0;
		left_bits  = 4'd0;
		left_count = 3'd0;
	endfunction

	// Works out every character that one accepted code unit causes and queues
	// them, flags included, behind what is already expected.
	function automatic void predict_chars(input logic [15:0] code, input logic last);
		logic [19:0] acc;
		logic [19:0] shifted;
		int cnt;
		int total;
		char_group.delete();
		if (code >= mu7enc_pkg::PrintLo && code <= mu7enc_pkg::PrintHi) begin
			close_open_run();
			emit_char(code[6:0]);
			if (code == mu7enc_pkg::UnitAmp) begin
				emit_char(mu7enc_pkg::CharDash);
			end
		end else begin
			cnt = left_count;
			if (!run_open) begin
				emit_char(mu7enc_pkg::CharAmp);
				run_open  = 1'b1;
				cnt       = 0;
				left_bits = 4'd0;
			end
			if (cnt > 4) begin
				cnt = 4;
			end
			acc   = {left_bits, code};
			total = cnt + 16;
			while (total >= 6) begin
				shifted = acc >> (total - 6);
				emit_digit(shifted[5:0]);
				total -= 6;
			end
			left_bits  = acc[3:0] & 4'((1 << total) - 1);
			left_count = 3'(total);
			if (last) begin
				close_open_run();
			end
		end
		char_group[char_group.size() - 1].end_item = 1'b1;
		if (last) begin
			char_group[char_group.size() - 1].end_string = 1'b1;
			run_open   = 1'b0;
			left_bits  = 4'd0;
			left_count = 3'd0;
		end
		expected_chars = {expected_chars, char_group};
	endfunction

	// Random units lean toward the interesting classes: printable ASCII, the
	// ampersand, control codes next to the printable range, and anything at all.
	function automatic logic [15:0] random_unit();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			return 16'($urandom_range(16'h0020, 16'h007E));
		end else if (pick < 45) begin
			return mu7enc_pkg::UnitAmp;
		end else if (pick < 55) begin
			return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 31)) : 16'h007F;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic push_unit(input logic [15:0] code, input logic last);
		unit_item_t u;
		u.code = code;
		u.last = last;
		pending_units = {pending_units, u};
	endtask

	// Waits until every queued unit has been taken and every predicted
	// character has come out. Sampling on the falling edge keeps this clear of
	// the updates made at the rising edge.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_units.size() != 0 || unit_valid || expected_chars.size() != 0);
	endtask

	// Driver: offers the next pending unit whenever the current one has been
	// taken or none is on the bus. An idle draw leaves the bus empty until the next draw.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid <= 1'b0;
			unit_code  <= 16'h0000;
			unit_last  <= 1'b0;
		end else if (!unit_valid || units_bus.ready) begin
			if (pending_units.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				unit_valid <= 1'b1;
				unit_code  <= pending_units[0].code;
				unit_last  <= pending_units[0].last;
				void'(pending_units.pop_front());
			end else begin
				unit_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each character taken against the oldest expectation, and
	// only then predicts for a unit taken at the same edge, so the outcome never
	// depends on which process runs first.
	always @(posedge clk or negedge arst_n) begin : char_monitor
		char_item_t want;
		if (!arst_n) begin
			char_ready <= 1'b0;
		end else begin
			if (chars_bus.valid && chars_bus.ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("character with nothing expected", chars_bus.out_char, 0);
				end else begin
					want = expected_chars.pop_front();
					if (chars_bus.out_char !== want.ch) begin
						report_mismatch("out_char", chars_bus.out_char, want.ch);
					end
					if (chars_bus.last_of_item !== want.end_item) begin
						report_mismatch("last_of_item", chars_bus.last_of_item, want.end_item);
					end
					if (chars_bus.last_of_string !== want.end_string) begin
						report_mismatch("last_of_string", chars_bus.last_of_string,
							want.end_string);
					end
				end
			end
			if (units_bus.valid && units_bus.ready) begin
				predict_chars(units_bus.code_unit, units_bus.last_unit);
			end
			char_ready <= !rx_hold && ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Long hold-off on the character side. The sender keeps offering units
	// meanwhile, so the encoder fills up and has to stall its input.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#100000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int len;
		run_open   = 1'b0;
		left_bits  = 4'd0;
		left_count = 3'd0;
		arst_n     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: printable edges, the ampersand in and out of a run,
		// runs that end on a six-bit boundary or with two or four bits left,
		// string ends inside a run and on printable units, all-ones and
		// all-zeros units and alternating bit patterns.
		push_unit(16'h0041, 1'b0);
		push_unit(16'h0020, 1'b0);
		push_unit(16'h007E, 1'b0);
		push_unit(mu7enc_pkg::UnitAmp, 1'b0);
		push_unit(16'h0000, 1'b0);
		push_unit(mu7enc_pkg::UnitAmp, 1'b0);
		push_unit(16'hFFFF, 1'b0);
		push_unit(16'h001F, 1'b0);
		push_unit(16'h007F, 1'b0);
		push_unit(16'h0062, 1'b0);
		push_unit(16'h00E9, 1'b1);
		push_unit(mu7enc_pkg::UnitAmp, 1'b1);
		push_unit(16'h8000, 1'b0);
		push_unit(16'h0001, 1'b1);
		push_unit(16'h0061, 1'b1);
		push_unit(16'h0021, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h00FF, 1'b0);
		push_unit(16'hD83D, 1'b0);
		push_unit(16'hDE00, 1'b0);
		push_unit(16'h007D, 1'b1);
		push_unit(16'h5555, 1'b0);
		push_unit(16'hAAAA, 1'b1);
		wait_drained();

		// Random part: whole strings of random length, in four pacing phases.
		// The first phase, with no idling or stalls, also carries the long hold-off.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 52;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 52;
				end
				default: begin
					sender_idle_pct    = 16;
					receiver_stall_pct = 16;
				end
			endcase
			sent = 0;
			while (sent < 100) begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					push_unit(random_unit(), k == len - 1);
				end
				sent += len;
			end
			if (phase == 0) begin
				pressure_go = 1'b1;
			end
			wait_drained();
		end

		// A little slack so that any stray character still gets caught.
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
